// ----- rtl/can_fd_packet_reassembler_assert.svh -----
// Assertion macros for the CAN FD packet reassembler.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef CAN_FD_PACKET_REASSEMBLER_ASSERT_SVH
`define CAN_FD_PACKET_REASSEMBLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CFDR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("CFDR assertion failed");
`define CFDR_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("CFDR assertion failed");
`else
`define CFDR_ASSERT(label, prop)
`define CFDR_ASSERT_NEXT(label, cond, prop)
`endif

`endif

// ----- rtl/cfdr_pkg.sv -----
// Shared constants, types and helper function of the CAN FD packet reassembler.
// No dependencies.
package cfdr_pkg;

  localparam int FRAME_BYTES  = 64;
  localparam int HEADER_BYTES = 8;
  localparam int MAX_FRAMES   = (255 + HEADER_BYTES + FRAME_BYTES - 1) / FRAME_BYTES;
  localparam int FN_W         = $clog2(MAX_FRAMES + 1);
  localparam int OFF_W        = $clog2(MAX_FRAMES * FRAME_BYTES);
  localparam int CMP_W        = OFF_W + 1;

  localparam logic [7:0] MARKER_RESET = 8'd254;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [5:0] byte_pos;
    logic       is_data_frame;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  packet_byte;
    logic [8:0]  packet_offset;
    logic        last_of_packet;
    logic [15:0] packets_done;
  } result_t;

  function automatic logic [FN_W-1:0] frames_for(logic [7:0] len);
    logic [9:0] sum;
    sum = {2'b00, len} + 10'(HEADER_BYTES + FRAME_BYTES - 1);
    return FN_W'(sum / FRAME_BYTES);
  endfunction

endpackage

// ----- rtl/cfdr_in_stage.sv -----
// Input register of the CAN FD packet reassembler: holds one beat until the core takes it.
// Depends on cfdr_pkg.
module cfdr_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cfdr_pkg::item_t in_item,
  output logic            held_valid,
  output cfdr_pkg::item_t held_item,
  input  logic            take
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

// ----- rtl/cfdr_core.sv -----
// Packet state and per-byte decision of the CAN FD packet reassembler.
// Depends on cfdr_pkg and can_fd_packet_reassembler_assert.svh.
`include "can_fd_packet_reassembler_assert.svh"

module cfdr_core (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        start_marker,
  input  cfdr_pkg::item_t   item,
  input  logic              step,
  output cfdr_pkg::result_t res
);

  logic                      collecting;
  logic                      frame_taken;
  logic [7:0]                payload_len;
  logic [cfdr_pkg::FN_W-1:0] frames_needed;
  logic [cfdr_pkg::FN_W-1:0] frame_number;
  logic [15:0]               completed_count;

  logic                      collecting_next;
  logic                      frame_taken_next;
  logic [7:0]                payload_len_next;
  logic [cfdr_pkg::FN_W-1:0] frames_needed_next;
  logic [cfdr_pkg::FN_W-1:0] frame_number_next;
  logic [15:0]               completed_count_next;

  logic [cfdr_pkg::CMP_W-1:0] offset;
  logic [cfdr_pkg::CMP_W-1:0] total;
  logic                       in_frame;
  logic                       last;

  always_comb begin
    collecting_next      = collecting;
    frame_taken_next     = frame_taken;
    payload_len_next     = payload_len;
    frames_needed_next   = frames_needed;
    frame_number_next    = frame_number;
    completed_count_next = completed_count;
    res                  = '0;
    last                 = 1'b0;

    if (item.byte_pos == 6'd0) begin
      frame_taken_next = 1'b0;
      if (collecting) begin
        if (({1'b0, frame_number} + {{cfdr_pkg::FN_W{1'b0}}, 1'b1}) >=
            {1'b0, frames_needed}) begin
          collecting_next = 1'b0;
        end else if (item.is_data_frame) begin
          frame_number_next = frame_number + 1'b1;
          frame_taken_next  = 1'b1;
        end
      end
      if (!collecting_next && item.is_data_frame && item.frame_byte == start_marker) begin
        collecting_next    = 1'b1;
        frame_taken_next   = 1'b1;
        frame_number_next  = '0;
        payload_len_next   = '0;
        frames_needed_next = cfdr_pkg::frames_for(8'd0);
      end
    end

    in_frame = {1'b0, item.byte_pos} < 7'(cfdr_pkg::FRAME_BYTES);

    if (frame_taken_next && collecting_next && in_frame) begin
      if (frame_number_next == '0 && item.byte_pos == 6'd1) begin
        payload_len_next   = item.frame_byte;
        frames_needed_next = cfdr_pkg::frames_for(item.frame_byte);
      end
    end

    offset = cfdr_pkg::CMP_W'(frame_number_next) * cfdr_pkg::CMP_W'(cfdr_pkg::FRAME_BYTES)
           + cfdr_pkg::CMP_W'(item.byte_pos);
    total  = cfdr_pkg::CMP_W'(payload_len_next) + cfdr_pkg::CMP_W'(cfdr_pkg::HEADER_BYTES);

    if (frame_taken_next && collecting_next && in_frame && offset < total) begin
      last = (offset == total - 1'b1);
      if (last) begin
        completed_count_next = completed_count + 16'd1;
        collecting_next      = 1'b0;
        frame_taken_next     = 1'b0;
      end
      res.valid          = 1'b1;
      res.packet_byte    = item.frame_byte;
      res.packet_offset  = offset[8:0];
      res.last_of_packet = last;
      res.packets_done   = completed_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting      <= 1'b0;
      frame_taken     <= 1'b0;
      payload_len     <= '0;
      frames_needed   <= cfdr_pkg::FN_W'(1);
      frame_number    <= '0;
      completed_count <= '0;
    end else if (step) begin
      collecting      <= collecting_next;
      frame_taken     <= frame_taken_next;
      payload_len     <= payload_len_next;
      frames_needed   <= frames_needed_next;
      frame_number    <= frame_number_next;
      completed_count <= completed_count_next;
    end
  end

  `CFDR_ASSERT_NEXT(a_last_closes, step && res.valid && res.last_of_packet, !collecting)
  `CFDR_ASSERT_NEXT(a_mid_keeps_open, step && res.valid && !res.last_of_packet, collecting)
  `CFDR_ASSERT(a_frame_in_range, !collecting || (frame_number < frames_needed))
  `CFDR_ASSERT(a_taken_needs_open, !frame_taken || collecting)

endmodule

// ----- rtl/can_fd_packet_reassembler.sv -----
// A beat accepted passes the input register and then the result register to the master side.
// Throughput: one beat per cycle unless m_tready stalls, set by the single input
// register feeding the result register; dropped bytes are taken but produce no output beat.
// Reset (rst, synchronous, active high): no packet open, count zero, marker 254.
// Depends on cfdr_pkg, cfdr_in_stage and cfdr_core.
module can_fd_packet_reassembler (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // frame_byte [7:0], byte_pos [13:8], zero [15:14]
  input  logic        s_tuser,   // is_data_frame [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // packet_byte [7:0], packet_offset [16:8],
                                 // packets_done [32:17], zero [39:33]
  output logic        m_tlast
);

  logic [7:0]        start_marker;
  cfdr_pkg::item_t   in_item;
  cfdr_pkg::item_t   held_item;
  logic              held_valid;
  logic              take;
  cfdr_pkg::result_t res;

  logic [7:0]  out_byte;
  logic [8:0]  out_offset;
  logic [15:0] out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= cfdr_pkg::MARKER_RESET;
    end else if (cfg_wr_en) begin
      start_marker <= cfg_wr_data;
    end
  end

  assign in_item.frame_byte    = s_tdata[7:0];
  assign in_item.byte_pos      = s_tdata[13:8];
  assign in_item.is_data_frame = s_tuser;

  assign take = held_valid && (!m_tvalid || m_tready);

  cfdr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  cfdr_core u_core (
    .clk          (clk),
    .rst          (rst),
    .start_marker (start_marker),
    .item         (held_item),
    .step         (take),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= take && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      out_byte   <= res.packet_byte;
      out_offset <= res.packet_offset;
      out_done   <= res.packets_done;
      m_tlast    <= res.last_of_packet;
    end
  end

  assign m_tdata = {7'd0, out_done, out_offset, out_byte};

endmodule

// ----- verif/can_fd_packet_reassembler_checker.sv -----
`timescale 1ns / 1ps
// Checker for the CAN FD packet reassembler: it watches the register port and both
// streams, predicts each output beat and compares it with the one that arrives.
// Depends on cfdr_pkg for the frame size, the reset marker and the result type.
module can_fd_packet_reassembler_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tlast,
  output int          mismatches,
  output int          outstanding
);

  logic [7:0]        marker;
  logic              pkt_open;
  logic              frame_in_pkt;
  logic [7:0]        pay_len;
  logic [2:0]        frames_total;
  logic [2:0]        frame_idx;
  logic [15:0]       done_count;
  cfdr_pkg::result_t packet_beats[$];

  function automatic logic [2:0] frames_spanned(input logic [7:0] len);
    int span;
    span = (int'(len) + cfdr_pkg::HEADER_BYTES + cfdr_pkg::FRAME_BYTES - 1)
           / cfdr_pkg::FRAME_BYTES;
    return span[2:0];
  endfunction

  task automatic clear_state();
    marker       = cfdr_pkg::MARKER_RESET;
    pkt_open     = 1'b0;
    frame_in_pkt = 1'b0;
    pay_len      = 8'd0;
    frames_total = 3'd1;
    frame_idx    = 3'd0;
    done_count   = 16'd0;
    packet_beats.delete();
  endtask

  task automatic predict_beat(input logic [7:0] b, input logic [5:0] pos, input logic data);
    int                offs;
    int                total;
    cfdr_pkg::result_t beat;
    if (pos == 6'd0) begin
      frame_in_pkt = 1'b0;
      if (pkt_open) begin
        if (int'(frame_idx) + 1 >= int'(frames_total)) begin
          pkt_open = 1'b0;
        end else if (data) begin
          frame_idx    = frame_idx + 3'd1;
          frame_in_pkt = 1'b1;
        end
      end
      if (!pkt_open && data && b == marker) begin
        pkt_open     = 1'b1;
        frame_in_pkt = 1'b1;
        frame_idx    = 3'd0;
        pay_len      = 8'd0;
        frames_total = frames_spanned(8'd0);
      end
    end
    if (frame_in_pkt && pkt_open && int'(pos) < cfdr_pkg::FRAME_BYTES) begin
      if (frame_idx == 3'd0 && pos == 6'd1) begin
        pay_len      = b;
        frames_total = frames_spanned(b);
      end
      offs  = int'(frame_idx) * cfdr_pkg::FRAME_BYTES + int'(pos);
      total = int'(pay_len) + cfdr_pkg::HEADER_BYTES;
      if (offs < total) begin
        beat.valid          = 1'b1;
        beat.packet_byte    = b;
        beat.packet_offset  = offs[8:0];
        beat.last_of_packet = (offs == total - 1);
        if (beat.last_of_packet) begin
          done_count   = done_count + 16'd1;
          pkt_open     = 1'b0;
          frame_in_pkt = 1'b0;
        end
        beat.packets_done = done_count;
        packet_beats.push_back(beat);
      end
    end
  endtask

  task automatic note_mismatch(input string what, input cfdr_pkg::result_t want,
                               input cfdr_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected byte=%02h offset=%0d last=%b done=%0d,",
               $realtime, what, want.packet_byte, want.packet_offset,
               want.last_of_packet, want.packets_done);
      $display("    got byte=%02h offset=%0d last=%b done=%0d",
               got.packet_byte, got.packet_offset, got.last_of_packet, got.packets_done);
    end
  endtask

  always @(posedge clk) begin : watch
    cfdr_pkg::result_t got;
    cfdr_pkg::result_t want;
    if (rst) begin
      clear_state();
      mismatches = 0;
    end else begin
      if (cfg_wr_en) begin
        marker = cfg_wr_data;
      end
      if (s_tvalid && s_tready) begin
        predict_beat(s_tdata[7:0], s_tdata[13:8], s_tuser);
      end
      if (m_tvalid && m_tready) begin
        got.valid          = 1'b1;
        got.packet_byte    = m_tdata[7:0];
        got.packet_offset  = m_tdata[16:8];
        got.packets_done   = m_tdata[32:17];
        got.last_of_packet = m_tlast;
        if (packet_beats.size() == 0) begin
          want = '0;
          note_mismatch("unexpected output beat", want, got);
        end else begin
          want = packet_beats.pop_front();
          if (got.packet_byte !== want.packet_byte ||
              got.packet_offset !== want.packet_offset ||
              got.last_of_packet !== want.last_of_packet ||
              got.packets_done !== want.packets_done) begin
            note_mismatch("output beat differs", want, got);
          end
        end
      end
    end
    outstanding = packet_beats.size();
  end

endmodule

// ----- verif/can_fd_packet_reassembler_tb.sv -----
`timescale 1ns / 1ps
// Top of the CAN FD packet reassembler testbench: clock, reset, marker writes, frame
// stimulus with random gaps and output stalls, and the final verdict.
// Depends on cfdr_pkg, the block and can_fd_packet_reassembler_checker.
module can_fd_packet_reassembler_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 300;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;
  int          mismatches;
  int          outstanding;

  logic [7:0]  cur_marker;
  int          items_sent;
  bit          send_gaps;
  bit          steady_out;
  int          ready_hold;
  int unsigned cycle_count;

  can_fd_packet_reassembler dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  can_fd_packet_reassembler_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      ready_hold = steady_out ? 0 : int'($urandom_range(0, 7));
      if ($urandom_range(0, 63) == 0) begin
        steady_out = !steady_out;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (ready_hold > 0) begin
      m_tready <= 1'b0;
      ready_hold--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat was taken.
  task automatic send_beat(input logic [7:0] b, input logic [5:0] pos, input logic data);
    int gap;
    gap = send_gaps ? int'($urandom_range(0, 7)) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, pos, b};
    s_tuser  <= data;
    items_sent++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] first, input logic [7:0] second,
                            input logic data, input int n, input bit rough);
    logic [7:0] b;
    logic [5:0] pos;
    logic       flag;
    send_gaps = ($urandom_range(0, 3) != 0);
    for (int p = 0; p < n; p++) begin
      pos = p[5:0];
      if (rough && $urandom_range(0, 7) == 0) begin
        pos = 6'($urandom_range(0, 63));
      end
      b    = (p == 0) ? first : (p == 1) ? second : 8'($urandom_range(0, 255));
      flag = (rough && p != 0) ? 1'($urandom_range(0, 1)) : data;
      send_beat(b, pos, flag);
    end
  endtask

  task automatic send_packet(input logic [7:0] len, input bit broken);
    int frames;
    int cut;
    int n;
    frames = (int'(len) + cfdr_pkg::HEADER_BYTES + cfdr_pkg::FRAME_BYTES - 1)
             / cfdr_pkg::FRAME_BYTES;
    cut    = broken ? int'($urandom_range(1, int'(len) + cfdr_pkg::HEADER_BYTES))
                    : int'(len) + cfdr_pkg::HEADER_BYTES + int'($urandom_range(0, 3));
    for (int f = 0; f < frames; f++) begin
      n = cut - f * cfdr_pkg::FRAME_BYTES;
      if (n <= 0) break;
      if (n > cfdr_pkg::FRAME_BYTES) n = cfdr_pkg::FRAME_BYTES;
      if (f > 0 && $urandom_range(0, 9) == 0) begin
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0,
                   int'($urandom_range(1, 6)), 1'b0);
      end
      send_frame((f == 0) ? cur_marker : 8'($urandom_range(0, 255)),
                 (f == 0) ? len : 8'($urandom_range(0, 255)), 1'b1, n, 1'b0);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_marker(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    cur_marker  = value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int         target;
    int         pick;
    logic [7:0] len;
    logic [7:0] value;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 8'd0;
    s_tvalid    = 1'b0;
    s_tdata     = 16'd0;
    s_tuser     = 1'b0;
    m_tready    = 1'b0;
    cur_marker  = cfdr_pkg::MARKER_RESET;
    items_sent  = 0;
    send_gaps   = 1'b1;
    steady_out  = 1'b0;
    ready_hold  = 0;
    cycle_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Idle bytes: mid-frame, remote frame with the marker, data frame without it.
    send_beat(8'h5A, 6'd5, 1'b1);
    send_beat(cfdr_pkg::MARKER_RESET, 6'd0, 1'b0);
    send_beat(8'h00, 6'd1, 1'b0);
    send_beat(8'h00, 6'd0, 1'b1);
    send_beat(8'hFF, 6'd63, 1'b1);
    // Eight-byte packet: a byte before the length, a repeated length byte.
    send_beat(cfdr_pkg::MARKER_RESET, 6'd0, 1'b1);
    send_beat(8'hFF, 6'd2, 1'b1);
    send_beat(8'h00, 6'd1, 1'b1);
    send_beat(8'h00, 6'd1, 1'b1);
    for (int p = 3; p < 8; p++) begin
      send_beat(8'(p * 37), p[5:0], 1'b1);
    end
    // A new frame once every frame of the open packet has begun.
    send_beat(cfdr_pkg::MARKER_RESET, 6'd0, 1'b1);
    send_beat(cfdr_pkg::MARKER_RESET, 6'd0, 1'b1);
    send_beat(8'hFF, 6'd63, 1'b1);
    send_beat(8'h01, 6'd0, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: value = 8'h00;
          2: value = 8'hFF;
          4: value = cfdr_pkg::MARKER_RESET;
          default: value = 8'($urandom_range(0, 255));
        endcase
        write_marker(value);
      end
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = int'($urandom_range(0, 99));
        if (pick < 75) begin
          case ($urandom_range(0, 19))
            0: len = 8'd0;
            1: len = 8'd255;
            2, 3: len = 8'($urandom_range(121, 255));
            4, 5, 6, 7: len = 8'($urandom_range(41, 120));
            default: len = 8'($urandom_range(0, 40));
          endcase
          send_packet(len, $urandom_range(0, 9) == 0);
        end else begin
          send_frame(($urandom_range(0, 3) == 0) ? cur_marker : 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     int'($urandom_range(1, 12)), 1'b1);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
